// ----- design/peer_statistics_counter_bank_defines.svh -----
// ----------------------------------------------------------------------------
// Peer statistics counter bank: assertion macros
// Shared assertion shorthands, clocked on aclk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef PEER_STATISTICS_COUNTER_BANK_DEFINES_SVH
`define PEER_STATISTICS_COUNTER_BANK_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/psc_pkg.sv -----
// ----------------------------------------------------------------------------
// Peer statistics counter bank package
// Status codes, command and result types shared by the front and back ends.
// ----------------------------------------------------------------------------
package psc_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_KIND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // Widest fields the parameter ranges can call for.
    localparam int MAX_SLOT_W  = 8;   // up to 256 peer slots
    localparam int MAX_CNT_W   = 9;   // peer count up to 256
    localparam int MAX_PADDR_W = 12;  // up to 256 x 16 peer counters
    localparam int KIND_W      = 7;
    localparam int VALUE_W     = 32;

    // Work the back end has to do for one word.
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_GLOBAL,
        ACT_PEER
    } action_t;

    // Classified word passed from the front end to the back end.
    typedef struct packed {
        action_t                  action;
        logic                     clear;    // newly learned slot, sweep its counters
        logic                     kind_ok;
        logic [1:0]               status;
        logic [KIND_W-1:0]        gkind;
        logic [MAX_PADDR_W-1:0]   paddr;
        logic [MAX_PADDR_W-1:0]   pbase;
        logic [MAX_SLOT_W-1:0]    slot;
        logic [MAX_CNT_W-1:0]     active;
        logic [VALUE_W-1:0]       value;
    } cmd_t;

    // One result word.
    typedef struct packed {
        logic [1:0]         status;
        logic [VALUE_W-1:0] counter_value;
        logic [3:0]         peer_slot;
        logic [4:0]         active_peers;
    } res_t;

endpackage

// ----- design/psc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/psc_front.sv -----
// ----------------------------------------------------------------------------
// Peer statistics front end
// Looks up the peer table, learns new peers and classifies each word.
// ----------------------------------------------------------------------------
module psc_front import psc_pkg::*; #(
    parameter int PEER_SLOTS   = 16,
    parameter int GLOBAL_KINDS = 77,
    parameter int PEER_KINDS   = 14,
    localparam int SLOT_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1,
    localparam int CNT_W  = $clog2(PEER_SLOTS + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic               opcode,
    input  logic [15:0]        peer_id,
    input  logic [KIND_W-1:0]  stat_kind,
    input  logic signed [31:0] add_value,
    output cmd_t               cmd,
    output logic [CNT_W-1:0]   active_cnt
);

    logic [15:0]          ids_reg [PEER_SLOTS];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 hit_any;
    logic [SLOT_W-1:0]    slot_hit;
    logic [SLOT_W-1:0]    slot_sel;
    logic                 full;
    logic                 new_slot;
    logic                 gkind_ok;
    logic                 pkind_ok;
    logic [MAX_PADDR_W-1:0] slot_wide;
    logic [MAX_PADDR_W-1:0] pbase;

    // Parallel match against the slots in use; ids in use are unique.
    always_comb begin
        hit_any  = 1'b0;
        slot_hit = '0;
        for (int i = 0; i < PEER_SLOTS; i++) begin
            if ((CNT_W'(i) < count_reg) && (ids_reg[i] == peer_id)) begin
                hit_any  = 1'b1;
                slot_hit = slot_hit | SLOT_W'(i);
            end
        end
    end

    // Slot choice, table state and kind checks.
    assign full     = (count_reg == CNT_W'(PEER_SLOTS));
    assign new_slot = opcode && !hit_any && !full;
    assign slot_sel = hit_any ? slot_hit : count_reg[SLOT_W-1:0];
    assign gkind_ok = ({1'b0, stat_kind} < (KIND_W + 1)'(GLOBAL_KINDS));
    assign pkind_ok = ({1'b0, stat_kind} < (KIND_W + 1)'(PEER_KINDS));
    assign count_next = count_reg + CNT_W'(new_slot);

    // Counter addresses of the chosen slot.
    assign slot_wide = MAX_PADDR_W'(slot_sel);
    assign pbase     = MAX_PADDR_W'(slot_wide * MAX_PADDR_W'(PEER_KINDS));

    // Build the command word.
    always_comb begin
        cmd         = '0;
        cmd.gkind   = stat_kind;
        cmd.value   = add_value;
        cmd.pbase   = pbase;
        cmd.paddr   = pbase + MAX_PADDR_W'(stat_kind);
        cmd.active  = MAX_CNT_W'(count_next);
        if (!opcode) begin
            cmd.kind_ok = gkind_ok;
            cmd.action  = gkind_ok ? ACT_GLOBAL : ACT_NONE;
            cmd.status  = gkind_ok ? ST_OK : ST_BAD_KIND;
        end else if (!hit_any && full) begin
            cmd.action = ACT_NONE;
            cmd.status = ST_FULL;
        end else begin
            cmd.kind_ok = pkind_ok;
            cmd.clear   = new_slot;
            cmd.action  = (new_slot || pkind_ok) ? ACT_PEER : ACT_NONE;
            cmd.status  = pkind_ok ? ST_OK : ST_BAD_KIND;
            cmd.slot    = MAX_SLOT_W'(slot_sel);
        end
    end

    // Learn a new peer when the word is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept && new_slot) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && new_slot) begin
            ids_reg[count_reg[SLOT_W-1:0]] <= peer_id;
        end
    end

    assign active_cnt = count_reg;

endmodule

// ----- design/psc_queue.sv -----
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module psc_queue import psc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic ready,
    input  logic pop,
    output logic valid,
    output cmd_t head
);

    cmd_t        entry_reg [2];
    logic        wptr_reg;
    logic        rptr_reg;
    logic [1:0]  fill_reg;
    logic        do_push;
    logic        do_pop;

    assign ready   = (fill_reg != 2'd2);
    assign valid   = (fill_reg != 2'd0);
    assign head    = entry_reg[rptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            if (do_push) begin
                wptr_reg <= !wptr_reg;
            end
            if (do_pop) begin
                rptr_reg <= !rptr_reg;
            end
            fill_reg <= fill_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- design/psc_back.sv -----
// ----------------------------------------------------------------------------
// Peer statistics back end
// Carries out counter updates on the counter RAMs and holds the result word.
// ----------------------------------------------------------------------------
module psc_back import psc_pkg::*; #(
    parameter int PEER_SLOTS   = 16,
    parameter int GLOBAL_KINDS = 77,
    parameter int PEER_KINDS   = 14
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    input  cmd_t q_cmd,
    output logic q_pop,
    input  logic m_ready,
    output logic res_valid,
    output res_t res
);

    localparam int GA_W  = (GLOBAL_KINDS > 1) ? $clog2(GLOBAL_KINDS) : 1;
    localparam int PDEP  = PEER_SLOTS * PEER_KINDS;
    localparam int PA_W  = (PDEP > 1) ? $clog2(PDEP) : 1;
    localparam int PK_W  = (PEER_KINDS > 1) ? $clog2(PEER_KINDS) : 1;
    localparam logic [PK_W-1:0] LAST_IDX = PK_W'(PEER_KINDS - 1);

    typedef enum logic [1:0] {
        B_IDLE,
        B_RMW,
        B_CLEAR
    } bstate_t;

    bstate_t                  state_reg, state_next;
    cmd_t                     cur_reg, cur_next;
    logic [PK_W-1:0]          idx_reg, idx_next;
    logic                     gv_reg, gv_next;
    logic                     res_valid_reg, res_valid_next;
    res_t                     res_reg, res_next;
    logic [GLOBAL_KINDS-1:0]  gvalid_reg;

    logic                     out_ok;
    logic                     g_we, g_re, p_we, p_re;
    logic [GA_W-1:0]          g_waddr, g_raddr;
    logic [PA_W-1:0]          p_waddr, p_raddr;
    logic [31:0]              g_rdata, p_rdata;
    logic [31:0]              wdata;
    logic [31:0]              base;
    logic [31:0]              sum;

    // Global counters, valid bits stand in for the reset clear.
    psc_ram #(.WIDTH(32), .DEPTH(GLOBAL_KINDS)) u_gram (
        .aclk  (aclk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (wdata),
        .re    (g_re),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    // Per-peer counters, cleared by a sweep when a slot is learned.
    psc_ram #(.WIDTH(32), .DEPTH(PDEP)) u_pram (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (wdata),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    assign out_ok = !res_valid_reg || m_ready;
    assign base   = (cur_reg.action == ACT_GLOBAL) ? (gv_reg ? g_rdata : 32'd0) : p_rdata;
    assign sum    = base + cur_reg.value;

    // Sequencer: pop, read, add and write back, or sweep a new slot.
    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        gv_next        = gv_reg;
        res_valid_next = res_valid_reg && !m_ready;
        res_next       = res_reg;
        q_pop          = 1'b0;
        g_we           = 1'b0;
        g_re           = 1'b0;
        p_we           = 1'b0;
        p_re           = 1'b0;
        g_waddr        = cur_reg.gkind[GA_W-1:0];
        g_raddr        = q_cmd.gkind[GA_W-1:0];
        p_waddr        = PA_W'(cur_reg.paddr);
        p_raddr        = PA_W'(q_cmd.paddr);
        wdata          = sum;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    case (q_cmd.action)
                        ACT_NONE: begin
                            if (out_ok) begin
                                q_pop                 = 1'b1;
                                res_valid_next        = 1'b1;
                                res_next.status       = q_cmd.status;
                                res_next.counter_value = 32'd0;
                                res_next.peer_slot    = q_cmd.slot[3:0];
                                res_next.active_peers = q_cmd.active[4:0];
                            end
                        end
                        ACT_GLOBAL: begin
                            q_pop      = 1'b1;
                            g_re       = 1'b1;
                            gv_next    = gvalid_reg[q_cmd.gkind[GA_W-1:0]];
                            cur_next   = q_cmd;
                            state_next = B_RMW;
                        end
                        ACT_PEER: begin
                            q_pop    = 1'b1;
                            cur_next = q_cmd;
                            idx_next = '0;
                            if (q_cmd.clear) begin
                                state_next = B_CLEAR;
                            end else begin
                                p_re       = 1'b1;
                                state_next = B_RMW;
                            end
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            B_RMW: begin
                if (out_ok) begin
                    g_we                   = (cur_reg.action == ACT_GLOBAL);
                    p_we                   = (cur_reg.action == ACT_PEER);
                    res_valid_next         = 1'b1;
                    res_next.status        = cur_reg.status;
                    res_next.counter_value = sum;
                    res_next.peer_slot     = cur_reg.slot[3:0];
                    res_next.active_peers  = cur_reg.active[4:0];
                    state_next             = B_IDLE;
                end
            end
            B_CLEAR: begin
                // One counter of the new slot a cycle; the chosen one takes the value.
                p_we    = 1'b1;
                p_waddr = PA_W'(cur_reg.pbase) + PA_W'(idx_reg);
                wdata   = (cur_reg.kind_ok && (idx_reg == cur_reg.gkind[PK_W-1:0])) ?
                          cur_reg.value : 32'd0;
                if (idx_reg != LAST_IDX) begin
                    idx_next = idx_reg + PK_W'(1);
                end else if (out_ok) begin
                    res_valid_next         = 1'b1;
                    res_next.status        = cur_reg.status;
                    res_next.counter_value = cur_reg.kind_ok ? cur_reg.value : 32'd0;
                    res_next.peer_slot     = cur_reg.slot[3:0];
                    res_next.active_peers  = cur_reg.active[4:0];
                    state_next             = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // State, global valid bits and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
            gvalid_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            cur_reg       <= cur_next;
            idx_reg       <= idx_next;
            gv_reg        <= gv_next;
            res_reg       <= res_next;
            if (g_we) begin
                gvalid_reg[g_waddr] <= 1'b1;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- design/peer_statistics_counter_bank.sv -----
// ----------------------------------------------------------------------------
// Peer statistics counter bank
// Global and per-peer 32-bit statistics counters with peer learning.
// ----------------------------------------------------------------------------
// Each word on the s_ channel adds a signed amount to one global counter
// (s_tuser low) or to one counter of a peer (s_tuser high); the peer is
// learned into the next free slot on first sight. Each word gives exactly one
// result word on the m_ channel: status, the counter's new value, the peer's
// slot and the number of peers in use.
// The front end classifies a word in the cycle it is accepted and queues it
// (two entries). The back end pops a word that changes no counter and
// registers its result directly; a counter update takes one read and one
// write on the counter RAM port; when a new peer is learned the slot's
// counters are cleared one RAM write a cycle, the addressed one taking the value.
// Reset clears all counters and empties the peer table; s_tready stays low
// while aresetn is low and the block takes words straight after reset. When
// m_tready is low the result waits in its output register, the back end holds
// and the queue fills, after which s_tready falls; no word is lost.
// ----------------------------------------------------------------------------
`include "peer_statistics_counter_bank_defines.svh"

module peer_statistics_counter_bank import psc_pkg::*; #(
    parameter int PEER_SLOTS   = 16,
    parameter int GLOBAL_KINDS = 77,
    parameter int PEER_KINDS   = 14
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // peer_id[15:0], stat_kind[22:16], add_value[54:23]
    input  logic [0:0]  s_tuser,  // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // counter_value[31:0], peer_slot[35:32], active_peers[40:36]
    output logic [1:0]  m_tuser   // status[1:0]
);

    localparam int CNT_W = $clog2(PEER_SLOTS + 1);

    logic               accept;
    logic               opcode;
    logic [15:0]        peer_id;
    logic [KIND_W-1:0]  stat_kind;
    logic signed [31:0] add_value;
    cmd_t               front_cmd;
    cmd_t               q_head;
    logic               q_ready;
    logic               q_valid;
    logic               q_pop;
    logic [CNT_W-1:0]   active_cnt;
    logic               res_valid;
    res_t               res;

    // Unpack the input word; nothing is taken while in reset.
    assign opcode    = s_tuser[0];
    assign peer_id   = s_tdata[15:0];
    assign stat_kind = s_tdata[22:16];
    assign add_value = s_tdata[54:23];
    assign s_tready  = q_ready && aresetn;
    assign accept    = s_tvalid && s_tready;

    psc_front #(
        .PEER_SLOTS   (PEER_SLOTS),
        .GLOBAL_KINDS (GLOBAL_KINDS),
        .PEER_KINDS   (PEER_KINDS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .opcode     (opcode),
        .peer_id    (peer_id),
        .stat_kind  (stat_kind),
        .add_value  (add_value),
        .cmd        (front_cmd),
        .active_cnt (active_cnt)
    );

    psc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (accept),
        .push_cmd (front_cmd),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    psc_back #(
        .PEER_SLOTS   (PEER_SLOTS),
        .GLOBAL_KINDS (GLOBAL_KINDS),
        .PEER_KINDS   (PEER_KINDS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (q_head),
        .q_pop     (q_pop),
        .m_ready   (m_tready),
        .res_valid (res_valid),
        .res       (res)
    );

    // Pack the result word.
    assign m_tvalid = res_valid;
    assign m_tuser  = res.status;
    assign m_tdata  = {7'd0, res.active_peers, res.peer_slot, res.counter_value};

    // Checks on the block's own logic.
    `PSC_ASSERT_NEXT(a_peer_count_monotonic, 1'b1,
                     active_cnt >= $past(active_cnt), "peer count fell")
    `PSC_ASSERT_SAME(a_fail_reads_zero, m_tvalid && (m_tuser != ST_OK),
                     m_tdata[31:0] == 32'd0, "failed update carries a counter value")
    `PSC_ASSERT_SAME(a_full_no_slot, m_tvalid && (m_tuser == ST_FULL),
                     (m_tdata[35:32] == 4'd0) && (m_tdata[40:36] == 5'(PEER_SLOTS)),
                     "table-full result inconsistent")

endmodule
